// ===== rtl/core/sdc_pkg.sv =====
// Shared constants for the subset difference counter.
`timescale 1ns / 1ps
package sdc_pkg;

  localparam int unsigned MAX_SUM = 4095;
  localparam int unsigned ADDR_W  = 12;
  localparam int unsigned VAL_W   = 12;
  localparam int unsigned TOTAL_W = 13;
  localparam int unsigned CNT_W   = 30;

  localparam logic [CNT_W-1:0]   MODULUS   = CNT_W'(1000000007);
  localparam logic [ADDR_W-1:0]  TOP_ADDR  = ADDR_W'(MAX_SUM);
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = TOTAL_W'(MAX_SUM);

endpackage

// ===== rtl/core/subset_difference_counter.sv =====
// Subset difference counter: sequenced update of a subset-sum count memory.
//
//  channel | ports                                   | handshake
//  --------+-----------------------------------------+---------------------------------
//  input   | value_i[11:0], last_i                   | transfer when start_i & !busy_o
//  result  | count_o[29:0], overflow_o               | done_o strobe, one cycle, no stall
//  config  | cfg_difference_i[11:0]                  | written when cfg_we_i
//
// One item walks one memory entry per cycle from the top sum down to value through the
// shared mod-add unit, followed by a drain state for the last write-back. A last item
// adds a read state, the result state and a clearing pass of the count memory. After
// reset the same clearing pass runs before busy_o drops.
// The receiver cannot stall; done_o is high for exactly one cycle per list.
`timescale 1ns / 1ps
module subset_difference_counter
  import sdc_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic [VAL_W-1:0]   value_i,
  input  logic               last_i,
  input  logic               cfg_we_i,
  input  logic [VAL_W-1:0]   cfg_difference_i,
  output logic               done_o,
  output logic [CNT_W-1:0]   count_o,
  output logic               overflow_o
);

  localparam logic [2:0] ST_CLEAR  = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_UPDATE = 3'd2;
  localparam logic [2:0] ST_DRAIN  = 3'd3;
  localparam logic [2:0] ST_READ   = 3'd4;
  localparam logic [2:0] ST_RESULT = 3'd5;

  logic [2:0]         state_q, state_d;
  logic [ADDR_W-1:0]  ptr_q, ptr_d;
  logic [VAL_W-1:0]   val_q, val_d;
  logic               last_q, last_d;
  logic [TOTAL_W-1:0] total_q, total_d;
  logic               ovf_q, ovf_d;
  logic [VAL_W-1:0]   diff_q;
  logic               p_valid_q, p_valid_d;
  logic [ADDR_W-1:0]  p_addr_q, p_addr_d;

  logic [CNT_W-1:0]   mem [0:MAX_SUM];
  logic [CNT_W-1:0]   rd_a_q, rd_b_q;
  logic [ADDR_W-1:0]  rd_addr_a, rd_addr_b;
  logic               mem_we;
  logic [ADDR_W-1:0]  mem_wa;
  logic [CNT_W-1:0]   mem_wd;

  logic               accept;
  logic [TOTAL_W-1:0] new_total;
  logic [TOTAL_W-1:0] rest;
  logic               hit;
  logic [CNT_W:0]     add_sum;
  logic [CNT_W-1:0]   add_mod;

  assign accept    = start_i && (state_q == ST_IDLE);
  assign new_total = total_q + TOTAL_W'(value_i);
  assign rest      = total_q - TOTAL_W'(diff_q);
  assign hit       = !ovf_q && (total_q >= TOTAL_W'(diff_q)) && !rest[0];

  // shared modular adder: both operands already reduced
  assign add_sum = {1'b0, rd_a_q} + {1'b0, rd_b_q};
  assign add_mod = (add_sum >= {1'b0, MODULUS}) ? CNT_W'(add_sum - {1'b0, MODULUS})
                                                 : add_sum[CNT_W-1:0];

  assign rd_addr_a = (state_q == ST_READ) ? rest[TOTAL_W-1:1] : ptr_q;
  assign rd_addr_b = ptr_q - val_q;

  always_comb begin
    if (state_q == ST_CLEAR) begin
      mem_we = 1'b1;
      mem_wa = ptr_q;
      mem_wd = (ptr_q == '0) ? CNT_W'(1) : '0;
    end else begin
      mem_we = p_valid_q;
      mem_wa = p_addr_q;
      mem_wd = add_mod;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_a_q <= mem[rd_addr_a];
    rd_b_q <= mem[rd_addr_b];
  end

  always_comb begin
    state_d   = state_q;
    ptr_d     = ptr_q;
    val_d     = val_q;
    last_d    = last_q;
    total_d   = total_q;
    ovf_d     = ovf_q;
    p_valid_d = 1'b0;
    p_addr_d  = p_addr_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (ptr_q == '0) begin
          state_d = ST_IDLE;
        end else begin
          ptr_d = ptr_q - ADDR_W'(1);
        end
      end
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_UPDATE;
          ptr_d   = TOP_ADDR;
          val_d   = value_i;
          last_d  = last_i;
          if (!ovf_q) begin
            if (new_total > TOTAL_MAX) begin
              ovf_d = 1'b1;
            end else begin
              total_d = new_total;
            end
          end
        end
      end
      ST_UPDATE: begin
        p_valid_d = 1'b1;
        p_addr_d  = ptr_q;
        if (ptr_q == val_q) begin
          state_d = ST_DRAIN;
        end else begin
          ptr_d = ptr_q - ADDR_W'(1);
        end
      end
      ST_DRAIN: begin
        state_d = last_q ? ST_READ : ST_IDLE;
      end
      ST_READ: begin
        state_d = ST_RESULT;
      end
      ST_RESULT: begin
        state_d = ST_CLEAR;
        ptr_d   = TOP_ADDR;
        total_d = '0;
        ovf_d   = 1'b0;
      end
      default: begin
        state_d = ST_CLEAR;
        ptr_d   = TOP_ADDR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      ptr_q     <= TOP_ADDR;
      last_q    <= 1'b0;
      total_q   <= '0;
      ovf_q     <= 1'b0;
      diff_q    <= '0;
      p_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      ptr_q     <= ptr_d;
      last_q    <= last_d;
      total_q   <= total_d;
      ovf_q     <= ovf_d;
      p_valid_q <= p_valid_d;
      if (cfg_we_i) begin
        diff_q <= cfg_difference_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    val_q    <= val_d;
    p_addr_q <= p_addr_d;
  end

  assign busy_o     = (state_q != ST_IDLE);
  assign done_o     = (state_q == ST_RESULT);
  assign count_o    = hit ? rd_a_q : '0;
  assign overflow_o = ovf_q;

  // the result strobe follows the target read
  a_done_after_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(state_q == ST_READ))
    else $error("result strobe without target read");

  // write-back only follows an update read
  a_wb_after_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    p_valid_q |-> $past(state_q == ST_UPDATE))
    else $error("write-back without update read");

  a_count_reduced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (count_o < MODULUS))
    else $error("count not reduced");

  a_ovf_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && overflow_o) |-> (count_o == '0))
    else $error("nonzero count with overflow");

  // a result always starts a clearing pass
  a_clear_after_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> (state_q == ST_CLEAR) && (total_q == '0) && !ovf_q)
    else $error("store not cleared after result");

endmodule
